### design/bmhq_pkg.sv
// Shared types, codes and sizes for the binary max-heap queue.
// No dependencies; the engine and the top-level unit import this package.
package bmhq_pkg;

    // Default number of heap entries
    localparam int BMHQ_CAPACITY = 1024;

    // Fixed field widths
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 11;

    // Operation codes
    localparam logic [1:0] OP_INSERT       = 2'd0;
    localparam logic [1:0] OP_DELETE_MAX   = 2'd1;
    localparam logic [1:0] OP_DELETE_VALUE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Request transaction payload
    typedef struct packed {
        logic        [1:0]        opcode;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // Response transaction payload
    typedef struct packed {
        logic        [1:0]         status;
        logic signed [DATA_W-1:0]  top_value;
        logic        [ENTRY_W-1:0] entry_count;
    } rsp_t;

endpackage

### design/bmhq_chan_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Used with bmhq_pkg::req_t and bmhq_pkg::rsp_t.
interface bmhq_chan_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### design/binary_max_heap_queue_unit.sv
// Binary max-heap priority queue of signed 32-bit values held in one RAM of CAPACITY
// words. Each request transaction carries an insert, a delete-max or a delete-by-value
// (the unnamed fourth opcode is a no-op), and each produces exactly one response with
// status, current maximum (-1 when empty) and entry count. One operation is in progress
// at a time. Insert climbs the new value toward the root; delete-max moves the last
// entry to the root and sinks it; delete-by-value scans one entry per cycle up to the
// match, then refills the hole from the tail and restores order. The heap RAM
// has registered read data. The fill count is cleared at reset, so there is no
// clearing pass.
// Depends on bmhq_pkg, bmhq_chan_if, bmhq_ram and bmhq_engine.
module binary_max_heap_queue_unit import bmhq_pkg::*; #(
    parameter int CAPACITY = BMHQ_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    bmhq_chan_if.sink    req,
    bmhq_chan_if.source  rsp
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    req_t              req_data;
    logic              out_valid_reg;
    rsp_t              out_data_reg;

    assign req_data = req.data;

    bmhq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    bmhq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Output register: accept a new result once the held one is taken
    assign res_ready = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

### design/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/bmhq_engine.sv
// Heap sequencer: runs insert, delete-max and delete-by-value against the heap RAM.
// Depends on bmhq_pkg; drives the ports of one bmhq_ram instance.
module bmhq_engine import bmhq_pkg::*; #(
    parameter int CAPACITY = BMHQ_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  req_t                        req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output rsp_t                        res,
    output logic                        we,
    output logic [$clog2(CAPACITY)-1:0] waddr,
    output logic [DATA_W-1:0]           wdata,
    output logic                        re,
    output logic [$clog2(CAPACITY)-1:0] raddr,
    input  logic [DATA_W-1:0]           rdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = IDX_W + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_LAST   = 4'd2;
    localparam logic [3:0] S_UPCHK  = 4'd3;
    localparam logic [3:0] S_UPCMP  = 4'd4;
    localparam logic [3:0] S_DNRDL  = 4'd5;
    localparam logic [3:0] S_DNRDR  = 4'd6;
    localparam logic [3:0] S_DNCMP  = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic                     rpend_reg, rpend_next;
    logic [1:0]               op_reg, op_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] hold_reg, hold_next;
    logic signed [DATA_W-1:0] lval_reg, lval_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]         ridx_reg, ridx_next;
    logic                     hasr_reg, hasr_next;
    logic                     first_reg, first_next;

    logic signed [DATA_W-1:0] rd_val;
    logic [CH_W-1:0]          child_l;
    logic [CH_W-1:0]          child_r;
    logic [CH_W-1:0]          cnt_ext;
    logic [IDX_W-1:0]         parent;
    logic [CNT_W-1:0]         last_idx;
    logic                     take_l;
    logic                     take_r;
    logic signed [DATA_W-1:0] best;

    assign rd_val   = $signed(rdata);
    assign child_l  = {1'b0, pos_reg, 1'b1};
    assign child_r  = child_l + CH_W'(1);
    assign cnt_ext  = CH_W'(cnt_reg);
    assign parent   = (pos_reg - IDX_W'(1)) >> 1;
    assign last_idx = cnt_reg - CNT_W'(1);

    // Pick the larger child; a child wins only when strictly greater, left on a tie
    assign take_l = lval_reg > hold_reg;
    assign best   = take_l ? lval_reg : hold_reg;
    assign take_r = hasr_reg && (rd_val > best);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);

    // Result fields
    always_comb
    begin
        res.status      = status_reg;
        res.top_value   = (cnt_reg == '0) ? -32'sd1 : top_reg;
        res.entry_count = ENTRY_W'(cnt_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        scan_next   = scan_reg;
        rpend_next  = rpend_reg;
        op_next     = op_reg;
        status_next = status_reg;
        key_next    = key_reg;
        hold_next   = hold_reg;
        lval_next   = lval_reg;
        pos_next    = pos_reg;
        ridx_next   = ridx_reg;
        hasr_next   = hasr_reg;
        first_next  = first_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = hold_reg;
        re          = 1'b0;
        raddr       = last_idx[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    status_next = ST_DONE;
                    rpend_next  = 1'b0;
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                status_next = ST_OVERFLOW;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                hold_next  = req.value;
                                pos_next   = cnt_reg[IDX_W-1:0];
                                cnt_next   = cnt_reg + CNT_W'(1);
                                first_next = 1'b1;
                                state_next = S_UPCHK;
                            end
                        end
                        OP_DELETE_MAX:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                cnt_next = last_idx;
                                if (last_idx == '0)
                                begin
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    // Fetch the last entry to move into the root
                                    re         = 1'b1;
                                    pos_next   = '0;
                                    state_next = S_LAST;
                                end
                            end
                        end
                        OP_DELETE_VALUE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                key_next   = req.value;
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rpend_reg && (rd_val == key_reg))
                begin
                    // Match found: drop the entry, refill from the tail
                    rpend_next = 1'b0;
                    cnt_next   = last_idx;
                    if (CNT_W'(ridx_reg) < last_idx)
                    begin
                        re         = 1'b1;
                        pos_next   = ridx_reg;
                        state_next = S_LAST;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (rpend_reg && (CNT_W'(ridx_reg) == last_idx))
                begin
                    rpend_next  = 1'b0;
                    status_next = ST_NOTFOUND;
                    state_next  = S_FINISH;
                end
                else if (scan_reg < cnt_reg)
                begin
                    // Issue the next linear read
                    re         = 1'b1;
                    raddr      = scan_reg[IDX_W-1:0];
                    ridx_next  = scan_reg[IDX_W-1:0];
                    scan_next  = scan_reg + CNT_W'(1);
                    rpend_next = 1'b1;
                end
                else
                begin
                    rpend_next = 1'b0;
                end
            end

            S_LAST:
            begin
                hold_next  = rd_val;
                first_next = 1'b1;
                state_next = (op_reg == OP_DELETE_MAX) ? S_DNRDL : S_UPCHK;
            end

            S_UPCHK:
            begin
                if (pos_reg == '0)
                begin
                    if (first_reg && (op_reg == OP_DELETE_VALUE))
                    begin
                        state_next = S_DNRDL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = parent;
                    state_next = S_UPCMP;
                end
            end

            S_UPCMP:
            begin
                if (hold_reg > rd_val)
                begin
                    // Move the parent down into the hole
                    we         = 1'b1;
                    wdata      = rd_val;
                    pos_next   = parent;
                    first_next = 1'b0;
                    state_next = S_UPCHK;
                end
                else if (first_reg && (op_reg == OP_DELETE_VALUE))
                begin
                    state_next = S_DNRDL;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_DNRDL:
            begin
                if (child_l >= cnt_ext)
                begin
                    we         = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = child_l[IDX_W-1:0];
                    state_next = S_DNRDR;
                end
            end

            S_DNRDR:
            begin
                lval_next  = rd_val;
                hasr_next  = child_r < cnt_ext;
                re         = child_r < cnt_ext;
                raddr      = child_r[IDX_W-1:0];
                state_next = S_DNCMP;
            end

            S_DNCMP:
            begin
                if (take_r)
                begin
                    we         = 1'b1;
                    wdata      = rd_val;
                    pos_next   = child_r[IDX_W-1:0];
                    state_next = S_DNRDL;
                end
                else if (take_l)
                begin
                    we         = 1'b1;
                    wdata      = lval_reg;
                    pos_next   = child_l[IDX_W-1:0];
                    state_next = S_DNRDL;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the root value on every write to entry zero
    always_comb
    begin
        top_next = top_reg;
        if (we && (waddr == '0))
        begin
            top_next = $signed(wdata);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rpend_reg  <= 1'b0;
            scan_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rpend_reg  <= rpend_next;
            scan_reg   <= scan_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        hold_reg   <= hold_next;
        lval_reg   <= lval_next;
        top_reg    <= top_next;
        pos_reg    <= pos_next;
        ridx_reg   <= ridx_next;
        hasr_reg   <= hasr_next;
        first_reg  <= first_next;
    end

    // Insert into a full heap reports overflow next cycle
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && req.opcode == OP_INSERT && cnt_reg == CNT_FULL)
        |=> (state_reg == S_FINISH && status_reg == ST_OVERFLOW))
        else $error("full insert did not report overflow");

    // Entry count stays within capacity
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond capacity");

    // No read and write of the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re && (waddr == raddr)))
        else $error("read and write hit the same entry");

    // A stalled result holds its count
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !res_ready)
        |=> (state_reg == S_FINISH && $stable(cnt_reg)))
        else $error("result dropped while stalled");

endmodule

### dv/binary_max_heap_queue_unit_tb.sv
// Self-checking testbench for binary_max_heap_queue_unit: drives insert, delete-max and
// delete-by-value transactions and checks every response against an in-bench heap.
// Depends on bmhq_pkg, bmhq_chan_if and the RTL of the block.
module binary_max_heap_queue_unit_tb;
    import bmhq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH     = BMHQ_CAPACITY;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;

    // Opcode three has no name in the package; the block treats it as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // One row of the directed script; pinned rows carry a hand-written response
    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
        logic                     pinned;
        rsp_t                     want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    bmhq_chan_if #(.T(req_t)) req_ch ();
    bmhq_chan_if #(.T(rsp_t)) rsp_ch ();

    binary_max_heap_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Heap image kept by the bench
    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int heap_count;
    int peak_fill;

    rsp_t awaited_results [$];
    step_t script [$];

    int fail_count;
    int items_sent;
    int inserts_done;
    int overflow_seen;
    int empty_seen;
    int miss_seen;
    int quiet_cycles;

    logic tx_idle_on;
    logic rx_idle_on;
    logic long_hold_pending;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Move a new entry toward the root while it beats its parent
    function automatic void climb(int pos);
        int up;
        logic signed [DATA_W-1:0] tmp;
        logic done;
        done = 1'b0;
        while (pos > 0 && !done)
        begin
            up = (pos - 1) / 2;
            if (heap_mem[pos] > heap_mem[up])
            begin
                tmp = heap_mem[pos];
                heap_mem[pos] = heap_mem[up];
                heap_mem[up] = tmp;
                pos = up;
            end
            else
                done = 1'b1;
        end
    endfunction

    // Push an entry toward the leaves, always swapping with the larger child
    function automatic void sink_down(int pos);
        int lc;
        int rc;
        int big;
        logic signed [DATA_W-1:0] tmp;
        logic done;
        done = 1'b0;
        while (pos < heap_count && !done)
        begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            big = pos;
            if (lc < heap_count && heap_mem[lc] > heap_mem[big])
                big = lc;
            if (rc < heap_count && heap_mem[rc] > heap_mem[big])
                big = rc;
            if (big == pos)
                done = 1'b1;
            else
            begin
                tmp = heap_mem[pos];
                heap_mem[pos] = heap_mem[big];
                heap_mem[big] = tmp;
                pos = big;
            end
        end
    endfunction

    // Apply one operation to the heap image and return the response it must produce
    function automatic rsp_t apply_heap_op(req_t t);
        rsp_t r;
        int hit;
        int pos;
        r.status = ST_DONE;
        case (t.opcode)
            OP_INSERT:
            begin
                if (heap_count >= HEAP_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    heap_mem[heap_count] = t.value;
                    climb(heap_count);
                    heap_count++;
                    inserts_done++;
                end
            end
            OP_DELETE_MAX:
            begin
                if (heap_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    heap_count--;
                    if (heap_count > 0)
                    begin
                        heap_mem[0] = heap_mem[heap_count];
                        sink_down(0);
                    end
                end
            end
            OP_DELETE_VALUE:
            begin
                hit = -1;
                for (pos = 0; pos < heap_count && hit < 0; pos++)
                    if (heap_mem[pos] == t.value)
                        hit = pos;
                if (heap_count == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    heap_count--;
                    if (hit < heap_count)
                    begin
                        heap_mem[hit] = heap_mem[heap_count];
                        climb(hit);
                        sink_down(hit);
                    end
                end
            end
            default: ;
        endcase
        case (r.status)
            ST_OVERFLOW: overflow_seen++;
            ST_EMPTY:    empty_seen++;
            ST_NOTFOUND: miss_seen++;
            default: ;
        endcase
        if (heap_count > peak_fill)
            peak_fill = heap_count;
        r.top_value = (heap_count == 0) ? -32'sd1 : heap_mem[0];
        r.entry_count = ENTRY_W'(heap_count);
        return r;
    endfunction

    function automatic step_t row(logic [1:0] op, logic signed [DATA_W-1:0] val,
                                  logic pin, logic [1:0] st,
                                  logic signed [DATA_W-1:0] top, int cnt);
        step_t s;
        s.opcode = op;
        s.value = val;
        s.pinned = pin;
        s.want.status = st;
        s.want.top_value = top;
        s.want.entry_count = ENTRY_W'(cnt);
        return s;
    endfunction

    // Mix of extremes, a narrow band that makes duplicates, and full-range values
    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            3: v = -32'sd1;
            4, 5, 6: v = $signed($urandom_range(0, 16)) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Draw an operation by weight; most searches target a stored value
    function automatic req_t pick_op(int ins_w, int dmax_w, int dval_w);
        req_t t;
        int r;
        r = $urandom_range(0, 99);
        t.value = rand_value();
        if (r < ins_w)
            t.opcode = OP_INSERT;
        else if (r < ins_w + dmax_w)
            t.opcode = OP_DELETE_MAX;
        else if (r < ins_w + dmax_w + dval_w)
        begin
            t.opcode = OP_DELETE_VALUE;
            if (heap_count > 0 && $urandom_range(0, 3) != 0)
                t.value = heap_mem[$urandom_range(0, heap_count - 1)];
        end
        else
            t.opcode = OP_NOP;
        return t;
    endfunction

    // Offer one transaction, predict at acceptance, then maybe idle
    task automatic run_item(req_t t, logic pinned, rsp_t want);
        rsp_t guess;
        req_ch.valid <= 1'b1;
        req_ch.data  <= t;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        guess = apply_heap_op(t);
        awaited_results.push_back(pinned ? want : guess);
        items_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic run_random(int n, int ins_w, int dmax_w, int dval_w);
        repeat (n) run_item(pick_op(ins_w, dmax_w, dval_w), 1'b0, '0);
    endtask

    // Stop offering and hold until every response is back
    task automatic quiesce();
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Response side: random back-pressure bursts and one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_pending = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected response status %0d top %0d count %0d",
                         $realtime, rsp_ch.data.status, rsp_ch.data.top_value,
                         rsp_ch.data.entry_count);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.data.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, want.status, rsp_ch.data.status);
                    fail_count++;
                end
                if (rsp_ch.data.top_value !== want.top_value)
                begin
                    $display("%0t: top_value mismatch: expected %0d, actual %0d",
                             $realtime, want.top_value, rsp_ch.data.top_value);
                    fail_count++;
                end
                if (rsp_ch.data.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $realtime, want.entry_count, rsp_ch.data.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Abort when neither channel has moved a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        req_t t;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        heap_count = 0;
        peak_fill = 0;
        fail_count = 0;
        items_sent = 0;
        inserts_done = 0;
        overflow_seen = 0;
        empty_seen = 0;
        miss_seen = 0;
        quiet_cycles = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        long_hold_pending = 1'b0;

        // Directed script: empty heap, extremes, equal keys, misses, emptying again
        script.push_back(row(OP_DELETE_MAX,   0,         1'b1, ST_EMPTY, -1, 0));
        script.push_back(row(OP_DELETE_VALUE, 5,         1'b1, ST_EMPTY, -1, 0));
        script.push_back(row(OP_NOP,          -1,        1'b1, ST_DONE, -1, 0));
        script.push_back(row(OP_INSERT,       VAL_MIN,   1'b1, ST_DONE, VAL_MIN, 1));
        script.push_back(row(OP_INSERT,       VAL_MAX,   1'b1, ST_DONE, VAL_MAX, 2));
        script.push_back(row(OP_INSERT,       0,         1'b1, ST_DONE, VAL_MAX, 3));
        script.push_back(row(OP_INSERT,       -1,        1'b1, ST_DONE, VAL_MAX, 4));
        script.push_back(row(OP_INSERT,       7,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_INSERT,       7,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_VALUE, 12345,     1'b1, ST_NOTFOUND, VAL_MAX, 6));
        script.push_back(row(OP_NOP,          32'sh5a5a5a5a, 1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_VALUE, 7,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_INSERT,       7,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_VALUE, VAL_MIN,   1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_INSERT,       32'shaaaaaaaa, 1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_VALUE, 32'sh55555555, 1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b0, ST_DONE, 0, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b1, ST_DONE, -1, 0));
        script.push_back(row(OP_DELETE_MAX,   0,         1'b1, ST_EMPTY, -1, 0));
        script.push_back(row(OP_INSERT,       -1,        1'b1, ST_DONE, -1, 1));
        script.push_back(row(OP_DELETE_VALUE, -1,        1'b1, ST_DONE, -1, 0));

        // Hold reset low, then release it at a clock edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            t.opcode = script[i].opcode;
            t.value  = script[i].value;
            run_item(t, script[i].pinned, script[i].want);
        end

        // Mixed traffic with idling on both sides
        run_random(100, 45, 20, 30);

        // Long response hold while requests keep coming, then a full pause
        tx_idle_on = 1'b0;
        long_hold_pending = 1'b1;
        run_random(30, 60, 15, 20);
        quiesce();
        tx_idle_on = 1'b1;

        // Fill to capacity
        while (heap_count < HEAP_DEPTH)
            run_random(1, 100, 0, 0);

        // Operations at full: overflow inserts and long scans
        run_random(3, 100, 0, 0);
        run_random(3, 0, 0, 100);
        run_random(3, 100, 0, 0);
        run_random(4, 0, 50, 50);

        // Drain part of the heap
        run_random(60, 15, 40, 40);

        // Final stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(80, 35, 30, 30);
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d operations: %0d stored inserts, %0d overflows, %0d empty deletes,",
                 items_sent, inserts_done, overflow_seen, empty_seen);
        $display("%0d searches without a match; heap reached %0d of %0d entries.",
                 miss_seen, peak_fill, HEAP_DEPTH);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
